/* rtl/core/crc16_frame_checker_macros.svh */
// Assertion macros used by the frame checker RTL.
`ifndef CRC16_FRAME_CHECKER_MACROS_SVH
`define CRC16_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CFC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame checker assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame checker assertion failed");

`endif

/* rtl/core/cfc_pkg.sv */
`default_nettype none

package cfc_pkg;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_HEADER  = 2'd1,
      STATUS_BAD_TRAILER = 2'd2,
      STATUS_BAD_CRC     = 2'd3
   } status_type;

   localparam logic [7:0]  HDR_BYTE = 8'hFE;
   localparam logic [7:0]  TRL_BYTE = 8'hBB;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'h0000;

   // Byte positions inside the frame; anything at or above POS_IDLE waits for a start.
   localparam logic [3:0] POS_HDR0    = 4'd0;
   localparam logic [3:0] POS_HDR1    = 4'd1;
   localparam logic [3:0] POS_CMD     = 4'd2;
   localparam logic [3:0] POS_LEN     = 4'd3;
   localparam logic [3:0] POS_DATA    = 4'd4;
   localparam logic [3:0] POS_CRC_HI  = 4'd5;
   localparam logic [3:0] POS_CRC_LO  = 4'd6;
   localparam logic [3:0] POS_TRAILER = 4'd7;
   localparam logic [3:0] POS_IDLE    = 4'd8;

   typedef struct packed {
      status_type status;
      logic [7:0] command;
      logic [7:0] data_value;
      logic       value_updated;
      logic [7:0] held_number;
   } rsp_type;

   // One byte of CRC-16, MSB first, no reflection.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/cfc_frame_tracker.sv */
`default_nettype none

// Frame position, CRC accumulation and final check for one byte per step.
module cfc_frame_tracker (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire logic [7:0]      rx_byte,
   input  wire logic            frame_start,
   input  wire logic [7:0]      value_command,
   output cfc_pkg::rsp_type     res,
   output logic                 res_valid
);

   logic [3:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic        hdr_good_ff, hdr_good_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  data_ff, data_in;
   logic [7:0]  crc_hi_ff, crc_hi_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [7:0]  stored_ff, stored_in;

   logic [3:0]  eff_pos;
   logic        active;
   logic        upd;
   cfc_pkg::status_type status;

   assign eff_pos = frame_start ? cfc_pkg::POS_HDR0 : pos_ff;
   assign active  = frame_start || (pos_ff < cfc_pkg::POS_IDLE);

   // Status priority: header, then trailer, then CRC.
   always_comb begin
      if (!hdr_good_ff) begin
         status = cfc_pkg::STATUS_BAD_HEADER;
      end else if (rx_byte != cfc_pkg::TRL_BYTE) begin
         status = cfc_pkg::STATUS_BAD_TRAILER;
      end else if ({crc_hi_ff, crc_lo_ff} != crc_ff) begin
         status = cfc_pkg::STATUS_BAD_CRC;
      end else begin
         status = cfc_pkg::STATUS_OK;
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      hdr_good_in = hdr_good_ff;
      cmd_in      = cmd_ff;
      data_in     = data_ff;
      crc_hi_in   = crc_hi_ff;
      crc_lo_in   = crc_lo_ff;
      stored_in   = stored_ff;
      upd         = 1'b0;
      res_valid   = 1'b0;
      if (step && active) begin
         pos_in = eff_pos + 4'd1;
         case (eff_pos)
            cfc_pkg::POS_HDR0: begin
               crc_in      = cfc_pkg::CRC_INIT;
               hdr_good_in = (rx_byte == cfc_pkg::HDR_BYTE);
            end
            cfc_pkg::POS_HDR1: begin
               hdr_good_in = hdr_good_ff && (rx_byte == cfc_pkg::HDR_BYTE);
            end
            cfc_pkg::POS_CMD: begin
               cmd_in = rx_byte;
               crc_in = cfc_pkg::crc_feed(crc_ff, rx_byte);
            end
            cfc_pkg::POS_LEN: begin
               crc_in = cfc_pkg::crc_feed(crc_ff, rx_byte);
            end
            cfc_pkg::POS_DATA: begin
               data_in = rx_byte;
               crc_in  = cfc_pkg::crc_feed(crc_ff, rx_byte);
            end
            cfc_pkg::POS_CRC_HI: begin
               crc_hi_in = rx_byte;
            end
            cfc_pkg::POS_CRC_LO: begin
               crc_lo_in = rx_byte;
            end
            default: begin
               // Trailer byte: the frame is complete.
               pos_in    = cfc_pkg::POS_IDLE;
               res_valid = 1'b1;
               if ((status == cfc_pkg::STATUS_OK) && (cmd_ff == value_command)) begin
                  upd       = 1'b1;
                  stored_in = data_ff;
               end
            end
         endcase
      end
   end

   assign res.status        = status;
   assign res.command       = cmd_ff;
   assign res.data_value    = data_ff;
   assign res.value_updated = upd;
   assign res.held_number   = stored_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= cfc_pkg::POS_IDLE;
         crc_ff      <= cfc_pkg::CRC_INIT;
         hdr_good_ff <= 1'b0;
         cmd_ff      <= 8'h00;
         data_ff     <= 8'h00;
         crc_hi_ff   <= 8'h00;
         crc_lo_ff   <= 8'h00;
         stored_ff   <= 8'h00;
      end else begin
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         hdr_good_ff <= hdr_good_in;
         cmd_ff      <= cmd_in;
         data_ff     <= data_in;
         crc_hi_ff   <= crc_hi_in;
         crc_lo_ff   <= crc_lo_in;
         stored_ff   <= stored_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/cfc_rsp_stage.sv */
`default_nettype none

// Result register; it can take a new result in the cycle the old one leaves.
module cfc_rsp_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire cfc_pkg::rsp_type res,
   output logic                  free,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cfc_pkg::rsp_type      rsp
);

   logic             valid_ff;
   cfc_pkg::rsp_type data_ff;

   assign free      = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (free && load) begin
         data_ff <= res;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/crc16_frame_checker.sv */
`default_nettype none

// Channel  Direction  Beat contents
// req      in         rx_byte, frame_start
// rsp      out        status, command, data_value, value_updated, held_number
// csr      in         value_command
//
// One byte beat is taken per cycle while the input register can drain; a byte is resolved
// against the frame state while it sits in the input register, and a trailer byte's verdict
// is registered as that byte moves on. The per-byte CRC step is shallow XOR logic.
// Reset is synchronous and active high; it puts the block in the waiting-for-start state.
// A stalled result only holds the pipe while the result register is full and not taken.
module crc16_frame_checker (
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_frame_start,

   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_status,
   output logic [7:0]      rsp_command,
   output logic [7:0]      rsp_data_value,
   output logic            rsp_value_updated,
   output logic [7:0]      rsp_held_number,

   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_value_command
);

   `include "crc16_frame_checker_macros.svh"

   // Configuration register; writes are always taken.
   logic [7:0] value_cmd_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_cmd_ff <= 8'h00;
      end else if (csr_valid && csr_ready) begin
         value_cmd_ff <= csr_value_command;
      end
   end

   // Input register. It drains whenever the result register can take a beat,
   // so a new byte is taken in the same cycle the held one moves on.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       advance;
   logic       step;

   assign req_ready = !in_valid_ff || advance;
   assign step      = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_rx_byte;
         in_start_ff <= req_frame_start;
      end
   end

   // Frame state and the check done on the trailer byte.
   cfc_pkg::rsp_type res;
   logic             res_valid;

   cfc_frame_tracker u_tracker (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .rx_byte       (in_byte_ff),
      .frame_start   (in_start_ff),
      .value_command (value_cmd_ff),
      .res           (res),
      .res_valid     (res_valid)
   );

   // Result register.
   cfc_pkg::rsp_type rsp;

   cfc_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .res       (res),
      .free      (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_status        = rsp.status;
   assign rsp_command       = rsp.command;
   assign rsp_data_value    = rsp.data_value;
   assign rsp_value_updated = rsp.value_updated;
   assign rsp_held_number   = rsp.held_number;

   // A byte held back by a full result register stays put in the input register.
   `CFC_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff) && $stable(in_start_ff))

   // A result only appears after a byte was processed in the cycle before.
   `CFC_ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rsp_valid), $past(step))

   // An update only comes from a good frame and publishes its data byte.
   `CFC_ASSERT_IMPLY(a_update_ok, clock, reset, rsp_valid && rsp_value_updated, (rsp_status == cfc_pkg::STATUS_OK) && (rsp_held_number == rsp_data_value))

endmodule

`default_nettype wire

/* tb/sv/crc16_frame_checker_test.sv */
`timescale 1ns / 100ps

module crc16_frame_checker_test;
   import cfc_pkg::*;

   // Cycles to wait once the last expected verdict is in, so that bytes which
   // give no verdict have left the two-stage pipe before a register write.
   localparam int PIPE_SETTLE = 8;
   // The run is declared hung after this many cycles with no beat on any channel.
   localparam int QUIET_LIMIT = 1000;
   // Frame bytes (not counting ignored ones) per value-command setting.
   localparam int PHASE_BYTES = 290;
   localparam int PHASE_COUNT = 6;

   // The tracker mirrors the frame state machine. Every accepted byte beat is
   // fed to it; on a trailer byte it queues the verdict that the block must
   // give, and each verdict beat from the block is matched against the oldest.
   class frame_verdict_tracker;
      logic [7:0]  watched_command = 8'h00;
      logic [3:0]  position = POS_IDLE;
      logic [15:0] running_crc = CRC_INIT;
      logic        header_ok = 1'b0;
      logic [7:0]  cmd_byte = 8'h00;
      logic [7:0]  data_byte = 8'h00;
      logic [7:0]  crc_hi = 8'h00;
      logic [7:0]  crc_lo = 8'h00;
      logic [7:0]  held = 8'h00;
      rsp_type     pending_verdicts[$];
      int          mismatches = 0;
      int          bytes_used = 0;
      int          bytes_ignored = 0;
      int          updates = 0;
      int          verdict_tally[4] = '{0, 0, 0, 0};

      // Bit-serial CRC-16 with polynomial 0x1021, most significant bit first.
      static function logic [15:0] fold_byte(logic [15:0] crc, logic [7:0] b);
         logic feedback;
         for (int i = 7; i >= 0; i--) begin
            feedback = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0} ^ (feedback ? CRC_POLY : 16'h0000);
         end
         return crc;
      endfunction

      function void take_byte(logic [7:0] b, logic start);
         rsp_type verdict;
         if (start) begin
            position = POS_HDR0;
         end else if (position >= POS_IDLE) begin
            bytes_ignored++;
            return;
         end
         bytes_used++;
         case (position)
            POS_HDR0: begin
               running_crc = CRC_INIT;
               header_ok = (b == HDR_BYTE);
            end
            POS_HDR1: header_ok = header_ok & (b == HDR_BYTE);
            POS_CMD: begin
               cmd_byte = b;
               running_crc = fold_byte(running_crc, b);
            end
            POS_LEN: running_crc = fold_byte(running_crc, b);
            POS_DATA: begin
               data_byte = b;
               running_crc = fold_byte(running_crc, b);
            end
            POS_CRC_HI: crc_hi = b;
            POS_CRC_LO: crc_lo = b;
            default: begin
               // Header beats trailer, trailer beats CRC.
               if (!header_ok) begin
                  verdict.status = STATUS_BAD_HEADER;
               end else if (b != TRL_BYTE) begin
                  verdict.status = STATUS_BAD_TRAILER;
               end else if ({crc_hi, crc_lo} != running_crc) begin
                  verdict.status = STATUS_BAD_CRC;
               end else begin
                  verdict.status = STATUS_OK;
               end
               verdict.value_updated = (verdict.status == STATUS_OK) &&
                                       (cmd_byte == watched_command);
               if (verdict.value_updated) begin
                  held = data_byte;
                  updates++;
               end
               verdict.command = cmd_byte;
               verdict.data_value = data_byte;
               verdict.held_number = held;
               verdict_tally[verdict.status]++;
               pending_verdicts.push_back(verdict);
               position = POS_IDLE;
               return;
            end
         endcase
         position = position + 4'd1;
      endfunction

      function void match_verdict(rsp_type got);
         rsp_type want;
         if (pending_verdicts.size() == 0) begin
            $display("%0t: verdict with none expected: status %0d cmd %02h data %02h upd %0b held %02h",
                     $time, got.status, got.command, got.data_value, got.value_updated,
                     got.held_number);
            mismatches++;
            return;
         end
         want = pending_verdicts.pop_front();
         if (got.status !== want.status || got.command !== want.command ||
             got.data_value !== want.data_value || got.value_updated !== want.value_updated ||
             got.held_number !== want.held_number) begin
            $display("%0t: verdict mismatch: expected status %0d cmd %02h data %02h upd %0b held %02h",
                     $time, want.status, want.command, want.data_value, want.value_updated,
                     want.held_number);
            $display("%0t:                   actual status %0d cmd %02h data %02h upd %0b held %02h",
                     $time, got.status, got.command, got.data_value, got.value_updated,
                     got.held_number);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_frame_start = 1'b0;

   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [7:0] rsp_command;
   logic [7:0] rsp_data_value;
   logic       rsp_value_updated;
   logic [7:0] rsp_held_number;

   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_value_command = 8'h00;

   frame_verdict_tracker tracker;

   // When set, neither the byte sender nor the verdict receiver inserts idle
   // cycles; the last phase of the run streams at full rate.
   bit steady = 1'b0;
   int stall_left = 0;
   int quiet_cycles = 0;

   crc16_frame_checker DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .req_frame_start   (req_frame_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_command       (rsp_command),
      .rsp_data_value    (rsp_data_value),
      .rsp_value_updated (rsp_value_updated),
      .rsp_held_number   (rsp_held_number),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_value_command (csr_value_command)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Verdict-side back-pressure: ready drops in random bursts, and once the run
   // turns steady it stays high after any burst under way has ended.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every verdict beat is checked against the oldest expectation. The values
   // read here are those from before the edge, so no ordering race exists.
   always @(posedge clock) begin : watch_verdicts
      rsp_type seen;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         seen.status = status_type'(rsp_status);
         seen.command = rsp_command;
         seen.data_value = rsp_data_value;
         seen.value_updated = rsp_value_updated;
         seen.held_number = rsp_held_number;
         tracker.match_verdict(seen);
      end
   end

   // Hang detector: any beat on any channel restarts the count.
   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready) ||
          (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d verdicts outstanding",
                  $time, QUIET_LIMIT, tracker.pending_verdicts.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Offers one byte beat and returns at the edge where it is taken. Valid is
   // left high afterwards so back-to-back bytes follow with no idle gap; a random
   // gap lowers it first, in its own time step.
   task automatic push_byte(input logic [7:0] b, input logic start);
      if (!steady && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_frame_start <= start;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.take_byte(b, start);
   endtask

   // Sends the first count bytes of a frame packed first byte highest; the
   // first one carries the start flag. A count under eight leaves a partial frame.
   task automatic send_frame(input logic [63:0] frame, input int count);
      for (int i = 0; i < count; i++) begin
         push_byte(frame[63 - 8 * i -: 8], i == 0);
      end
   endtask

   function automatic logic [63:0] good_frame(logic [7:0] cmd, logic [7:0] len,
                                              logic [7:0] data);
      logic [15:0] crc;
      crc = frame_verdict_tracker::fold_byte(CRC_INIT, cmd);
      crc = frame_verdict_tracker::fold_byte(crc, len);
      crc = frame_verdict_tracker::fold_byte(crc, data);
      return {HDR_BYTE, HDR_BYTE, cmd, len, data, crc, TRL_BYTE};
   endfunction

   // Stops sending, waits for every outstanding verdict and then lets the
   // pipe settle, so that the block is idle.
   task automatic drain_frames();
      req_valid <= 1'b0;
      while (tracker.pending_verdicts.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_value_command(input logic [7:0] code);
      drain_frames();
      csr_valid <= 1'b1;
      csr_value_command <= code;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      tracker.watched_command = code;
   endtask

   // One random chunk of traffic. Most chunks are well-formed frames whose
   // command often matches the watched code, so the update path is exercised;
   // the rest are frames with corrupted bytes, frames cut short before their trailer,
   // frames followed by stray bytes, and loose noise.
   task automatic send_random_traffic();
      int          pick;
      int          pos;
      logic [7:0]  cmd;
      logic [63:0] frame;
      cmd = ($urandom_range(0, 1) == 1) ? tracker.watched_command : 8'($urandom);
      frame = good_frame(cmd, 8'($urandom), 8'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         send_frame(frame, 8);
      end else if (pick < 75) begin
         // Corrupt one byte, sometimes two, so that the status priority is hit.
         pos = $urandom_range(0, 7);
         frame[63 - 8 * pos -: 8] = frame[63 - 8 * pos -: 8] ^ 8'($urandom_range(1, 255));
         if ($urandom_range(0, 2) == 0) begin
            pos = $urandom_range(0, 7);
            frame[63 - 8 * pos -: 8] = frame[63 - 8 * pos -: 8] ^ 8'($urandom_range(1, 255));
         end
         send_frame(frame, 8);
      end else if (pick < 85) begin
         send_frame(frame, $urandom_range(1, 7));
      end else if (pick < 92) begin
         send_frame(frame, 8);
         repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
      end else begin
         repeat ($urandom_range(1, 10)) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      logic [7:0]  settings [PHASE_COUNT];
      logic [63:0] frame;
      int          goal;
      tracker = new;
      // Both extremes of the watched code, plus a few others.
      settings[0] = 8'h00;
      settings[1] = 8'hFF;
      settings[2] = 8'($urandom);
      settings[3] = 8'h80;
      settings[4] = 8'($urandom);
      settings[5] = 8'h01;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, run with the watched code at its reset value of zero.
      // A good frame with command 00 and data FF must update the held number.
      send_frame(good_frame(8'h00, 8'hFF, 8'hFF), 8);
      // A stray byte after the trailer is ignored.
      push_byte(8'h00, 1'b0);
      // A start in the middle of a frame drops the partial frame silently.
      send_frame(good_frame(8'h12, 8'h34, 8'h56), 3);
      // Every check fails at once: the bad header must win.
      frame = good_frame(8'hFF, 8'h00, 8'h00);
      frame[63:56] = 8'h00;
      frame[23:16] = frame[23:16] ^ 8'h01;
      frame[7:0] = 8'h00;
      send_frame(frame, 8);
      // Good header, bad trailer and bad CRC: the trailer must win, and a bad
      // frame with the watched command must not update the held number.
      frame = good_frame(8'h00, 8'h00, 8'h7E);
      frame[15:8] = frame[15:8] ^ 8'h80;
      frame[7:0] = 8'hFF;
      send_frame(frame, 8);

      // Random part, one phase per watched code. Each register write waits
      // until all outstanding verdicts are in, which also makes the sender
      // pause for a full drain at every phase boundary.
      goal = tracker.bytes_used;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         write_value_command(settings[phase]);
         steady = (phase == PHASE_COUNT - 1);
         goal += PHASE_BYTES;
         while (tracker.bytes_used < goal) send_random_traffic();
      end

      req_valid <= 1'b0;
      while (tracker.pending_verdicts.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);

      $display("Sent %0d frame bytes (%0d more ignored while idle) across %0d watched codes.",
               tracker.bytes_used, tracker.bytes_ignored, PHASE_COUNT);
      $display("Verdicts: %0d ok (%0d updates), %0d bad header, %0d bad trailer, %0d bad CRC.",
               tracker.verdict_tally[STATUS_OK], tracker.updates,
               tracker.verdict_tally[STATUS_BAD_HEADER],
               tracker.verdict_tally[STATUS_BAD_TRAILER],
               tracker.verdict_tally[STATUS_BAD_CRC]);
      if (tracker.mismatches == 0 && tracker.pending_verdicts.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
